// ===== src/lbs_pkg.sv =====
// Shared constants, types and control structs for the longest bitonic subsequence block.
// Used by lbs_cell and by the top level longest_bitonic_subsequence. No dependencies.
package lbs_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int LEN_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = LEN_W + 1;
    localparam int ELEM_W    = 16;
    localparam int TOTAL_W   = 6;
    localparam int DATA_W    = 24;

    typedef enum logic [1:0] {
        PASS_INC,
        PASS_DEC,
        PASS_PEAK
    } pass_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INC_GO,
        S_INC_WAIT,
        S_DEC_GO,
        S_DEC_WAIT,
        S_PEAK_GO,
        S_PEAK_WAIT,
        S_MARK,
        S_EMIT_INC,
        S_EMIT_DEC
    } state_t;

    // Token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic                     valid;
        pass_t                    kind;
        logic signed [ELEM_W-1:0] query;
        logic [IDX_W-1:0]         target;
        logic [LEN_W-1:0]         count;
        logic [SUM_W-1:0]         best;
        logic [IDX_W-1:0]         best_idx;
    } tok_t;

    // Writes broadcast from the sequencer; a cell acts when idx selects it.
    typedef struct packed {
        logic                     en_elem;
        logic                     en_inc;
        logic                     en_dec;
        logic                     mark_set;
        logic                     mark_clr;
        logic [IDX_W-1:0]         idx;
        logic signed [ELEM_W-1:0] value;
        logic [LEN_W-1:0]         len;
        logic [IDX_W-1:0]         link;
    } cell_ctl_t;

endpackage

// ===== src/lbs_cell.sv =====
// One cell of the row: holds one element with its run lengths and links,
// and updates the passing token. Depends on lbs_pkg.
module lbs_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lbs_pkg::IDX_W-1:0]        cell_idx,
    input  lbs_pkg::cell_ctl_t               ctl,
    input  lbs_pkg::tok_t                    tok_in,
    output lbs_pkg::tok_t                    tok_out,
    output logic signed [lbs_pkg::ELEM_W-1:0] elem,
    output logic [lbs_pkg::IDX_W-1:0]        pred,
    output logic [lbs_pkg::IDX_W-1:0]        succ,
    output logic                             marked
);

    logic signed [lbs_pkg::ELEM_W-1:0] elem_reg;
    logic [lbs_pkg::LEN_W-1:0]         inc_reg;
    logic [lbs_pkg::LEN_W-1:0]         dec_reg;
    logic [lbs_pkg::IDX_W-1:0]         pred_reg;
    logic [lbs_pkg::IDX_W-1:0]         succ_reg;
    logic                              mark_reg;
    lbs_pkg::tok_t                     tok_reg;
    lbs_pkg::tok_t                     tok_next;
    logic                              sel;
    logic                              in_set;
    logic [lbs_pkg::SUM_W-1:0]         cand_inc;
    logic [lbs_pkg::SUM_W-1:0]         cand_dec;
    logic [lbs_pkg::SUM_W-1:0]         t_sum;

    assign sel      = (ctl.idx == cell_idx);
    assign in_set   = (lbs_pkg::LEN_W'(cell_idx) < tok_in.count);
    assign cand_inc = lbs_pkg::SUM_W'(inc_reg) + lbs_pkg::SUM_W'(1);
    assign cand_dec = lbs_pkg::SUM_W'(dec_reg) + lbs_pkg::SUM_W'(1);
    assign t_sum    = lbs_pkg::SUM_W'(inc_reg) + lbs_pkg::SUM_W'(dec_reg)
                      - lbs_pkg::SUM_W'(1);

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid) begin
            unique case (tok_in.kind)
                lbs_pkg::PASS_INC: begin
                    if (cell_idx < tok_in.target && tok_in.query > elem_reg
                        && cand_inc > tok_in.best) begin
                        tok_next.best     = cand_inc;
                        tok_next.best_idx = cell_idx;
                    end
                end
                lbs_pkg::PASS_DEC: begin
                    // Ascending walk: a tie goes to the later cell once a link exists.
                    if (cell_idx > tok_in.target && in_set && tok_in.query > elem_reg
                        && (cand_dec > tok_in.best || (cand_dec == tok_in.best
                            && tok_in.best_idx != tok_in.target))) begin
                        tok_next.best     = cand_dec;
                        tok_next.best_idx = cell_idx;
                    end
                end
                lbs_pkg::PASS_PEAK: begin
                    if (in_set && t_sum > tok_in.best) begin
                        tok_next.best     = t_sum;
                        tok_next.best_idx = cell_idx;
                    end
                end
                default: begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= '0;
            mark_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (ctl.mark_clr) begin
                mark_reg <= 1'b0;
            end else if (ctl.mark_set && sel) begin
                mark_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_elem && sel) begin
            elem_reg <= ctl.value;
        end
        if (ctl.en_inc && sel) begin
            inc_reg  <= ctl.len;
            pred_reg <= ctl.link;
        end
        if (ctl.en_dec && sel) begin
            dec_reg  <= ctl.len;
            succ_reg <= ctl.link;
        end
    end

    assign tok_out = tok_reg;
    assign elem    = elem_reg;
    assign pred    = pred_reg;
    assign succ    = succ_reg;
    assign marked  = mark_reg;

endmodule

// ===== src/longest_bitonic_subsequence.sv =====
// Loading accepts one beat per cycle. After the beat with tlast, each element gets an
// increasing and a decreasing pass (a token walk down the cell row), then one peak
// pass runs, the increasing chain that ends at the peak is marked element by element,
// and total_length+1 beats are output after a scan of up to peak+1 cells.
// One set is worked on at a time. Synchronous active-low reset empties the element count.
// Depends on lbs_pkg and lbs_cell.
module longest_bitonic_subsequence (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] value
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lbs_pkg::DATA_W-1:0]   m_tdata,   // [15:0] elem, [21:16] total_length
    output logic                         m_tuser,   // [0] part
    output logic                         m_tlast
);

    localparam int N = lbs_pkg::MAX_ITEMS;

    lbs_pkg::state_t                    state_reg, state_next;
    logic [lbs_pkg::LEN_W-1:0]          count_reg, count_next;
    logic [lbs_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [lbs_pkg::IDX_W-1:0]          peak_reg, peak_next;
    logic [lbs_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic                               m_valid_reg;
    logic [lbs_pkg::DATA_W-1:0]         m_data_reg;
    logic                               m_user_reg;
    logic                               m_last_reg;

    lbs_pkg::cell_ctl_t                 ctl;
    lbs_pkg::tok_t                      tok_head;
    lbs_pkg::tok_t                      chain_tok [N+1];
    lbs_pkg::tok_t                      last_tok;
    logic signed [lbs_pkg::ELEM_W-1:0]  elem_arr [N];
    logic [lbs_pkg::IDX_W-1:0]          pred_arr [N];
    logic [lbs_pkg::IDX_W-1:0]          succ_arr [N];
    logic                               mark_arr [N];
    logic [N-1:0]                       tok_valid_vec;

    logic                               in_acc;
    logic                               out_free;
    logic                               emit;
    logic                               emit_part;
    logic                               emit_last;
    logic [lbs_pkg::IDX_W-1:0]          last_idx;
    logic signed [lbs_pkg::ELEM_W-1:0]  elem_rd;
    logic [lbs_pkg::IDX_W-1:0]          pred_rd;
    logic [lbs_pkg::IDX_W-1:0]          succ_rd;
    logic                               mark_rd;

    assign chain_tok[0] = tok_head;

    for (genvar k = 0; k < N; k++) begin : g_cell
        lbs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (lbs_pkg::IDX_W'(k)),
            .ctl      (ctl),
            .tok_in   (chain_tok[k]),
            .tok_out  (chain_tok[k+1]),
            .elem     (elem_arr[k]),
            .pred     (pred_arr[k]),
            .succ     (succ_arr[k]),
            .marked   (mark_arr[k])
        );
        assign tok_valid_vec[k] = chain_tok[k+1].valid;
    end

    assign last_tok = chain_tok[N];
    assign s_tready = (state_reg == lbs_pkg::S_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign last_idx = lbs_pkg::IDX_W'(count_reg - lbs_pkg::LEN_W'(1));
    assign elem_rd  = elem_arr[idx_reg];
    assign pred_rd  = pred_arr[idx_reg];
    assign succ_rd  = succ_arr[idx_reg];
    assign mark_rd  = mark_arr[idx_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lbs_pkg::S_LOAD;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        peak_reg  <= peak_next;
        total_reg <= total_next;
        if (emit) begin
            m_data_reg <= lbs_pkg::DATA_W'({total_reg, elem_rd});
            m_user_reg <= emit_part;
            m_last_reg <= emit_last;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        peak_next    = peak_reg;
        total_next   = total_reg;
        ctl          = '0;
        tok_head     = '0;
        emit         = 1'b0;
        emit_part    = 1'b0;
        emit_last    = 1'b0;
        unique case (state_reg)
            lbs_pkg::S_LOAD: begin
                if (in_acc) begin
                    if (count_reg < lbs_pkg::LEN_W'(N)) begin
                        ctl.en_elem = 1'b1;
                        ctl.idx     = count_reg[lbs_pkg::IDX_W-1:0];
                        ctl.value   = s_tdata;
                        count_next  = count_reg + lbs_pkg::LEN_W'(1);
                    end
                    if (s_tlast) begin
                        idx_next   = '0;
                        state_next = lbs_pkg::S_INC_GO;
                    end
                end
            end
            lbs_pkg::S_INC_GO, lbs_pkg::S_DEC_GO: begin
                tok_head.valid    = 1'b1;
                tok_head.kind     = (state_reg == lbs_pkg::S_INC_GO) ?
                                    lbs_pkg::PASS_INC : lbs_pkg::PASS_DEC;
                tok_head.query    = elem_rd;
                tok_head.target   = idx_reg;
                tok_head.count    = count_reg;
                tok_head.best     = lbs_pkg::SUM_W'(1);
                tok_head.best_idx = idx_reg;
                state_next = (state_reg == lbs_pkg::S_INC_GO) ?
                             lbs_pkg::S_INC_WAIT : lbs_pkg::S_DEC_WAIT;
            end
            lbs_pkg::S_INC_WAIT: begin
                if (last_tok.valid) begin
                    ctl.en_inc = 1'b1;
                    ctl.idx    = last_tok.target;
                    ctl.len    = lbs_pkg::LEN_W'(last_tok.best);
                    ctl.link   = last_tok.best_idx;
                    if (idx_reg == last_idx) begin
                        state_next = lbs_pkg::S_DEC_GO;
                    end else begin
                        idx_next   = idx_reg + lbs_pkg::IDX_W'(1);
                        state_next = lbs_pkg::S_INC_GO;
                    end
                end
            end
            lbs_pkg::S_DEC_WAIT: begin
                if (last_tok.valid) begin
                    ctl.en_dec = 1'b1;
                    ctl.idx    = last_tok.target;
                    ctl.len    = lbs_pkg::LEN_W'(last_tok.best);
                    ctl.link   = last_tok.best_idx;
                    if (idx_reg == '0) begin
                        state_next = lbs_pkg::S_PEAK_GO;
                    end else begin
                        idx_next   = idx_reg - lbs_pkg::IDX_W'(1);
                        state_next = lbs_pkg::S_DEC_GO;
                    end
                end
            end
            lbs_pkg::S_PEAK_GO: begin
                ctl.mark_clr      = 1'b1;
                tok_head.valid    = 1'b1;
                tok_head.kind     = lbs_pkg::PASS_PEAK;
                tok_head.count    = count_reg;
                state_next        = lbs_pkg::S_PEAK_WAIT;
            end
            lbs_pkg::S_PEAK_WAIT: begin
                if (last_tok.valid) begin
                    peak_next  = last_tok.best_idx;
                    total_next = lbs_pkg::TOTAL_W'(last_tok.best);
                    idx_next   = last_tok.best_idx;
                    state_next = lbs_pkg::S_MARK;
                end
            end
            lbs_pkg::S_MARK: begin
                // Flag every cell on the increasing chain that ends at the peak.
                ctl.mark_set = 1'b1;
                ctl.idx      = idx_reg;
                if (pred_rd == idx_reg) begin
                    idx_next   = '0;
                    state_next = lbs_pkg::S_EMIT_INC;
                end else begin
                    idx_next = pred_rd;
                end
            end
            lbs_pkg::S_EMIT_INC: begin
                if (!mark_rd) begin
                    idx_next = idx_reg + lbs_pkg::IDX_W'(1);
                end else if (out_free) begin
                    emit = 1'b1;
                    if (idx_reg == peak_reg) begin
                        state_next = lbs_pkg::S_EMIT_DEC;
                    end else begin
                        idx_next = idx_reg + lbs_pkg::IDX_W'(1);
                    end
                end
            end
            lbs_pkg::S_EMIT_DEC: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_part = 1'b1;
                    emit_last = (succ_rd == idx_reg);
                    if (succ_rd == idx_reg) begin
                        count_next = '0;
                        state_next = lbs_pkg::S_LOAD;
                    end else begin
                        idx_next = succ_rd;
                    end
                end
            end
            default: begin
                state_next = lbs_pkg::S_LOAD;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // Only one token may be in the cell row at any time.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valid_vec))
        else $error("more than one token in the cell row");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lbs_pkg::S_LOAD) |-> (tok_valid_vec == '0))
        else $error("token in flight while loading");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lbs_pkg::LEN_W'(N))
        else $error("element count beyond capacity");

    a_emit_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && state_reg == lbs_pkg::S_EMIT_INC) |-> mark_rd)
        else $error("increasing part emitted from an unmarked cell");
`endif

endmodule

// ===== tb/lbs_checker.sv =====
// Checker for the longest bitonic subsequence block: watches both stream channels,
// predicts each run's results from the accepted input beats and compares them.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
module lbs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [lbs_pkg::DATA_W-1:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending,
    output int          run_count
);

    typedef struct packed {
        logic signed [lbs_pkg::ELEM_W-1:0] elem;
        logic                              part;
        logic [lbs_pkg::TOTAL_W-1:0]       total;
        logic                              eor;
    } chain_beat_t;

    chain_beat_t subseq_q[$];
    logic signed [lbs_pkg::ELEM_W-1:0] set_vals[lbs_pkg::MAX_ITEMS];
    int set_len;

    // Works out the bitonic subsequence of the stored set and queues its beats.
    task automatic predict_subseq();
        int inc_len[lbs_pkg::MAX_ITEMS], dec_len[lbs_pkg::MAX_ITEMS];
        int pred[lbs_pkg::MAX_ITEMS], succ[lbs_pkg::MAX_ITEMS];
        int chain[lbs_pkg::MAX_ITEMS];
        int best, peak, t, idx, ninc, ndec;
        chain_beat_t b;
        best = 0;
        peak = 0;
        for (int i = 0; i < set_len; i++) begin
            inc_len[i] = 1;
            pred[i] = i;
            for (int j = 0; j < i; j++)
                if (set_vals[i] > set_vals[j] && inc_len[j] + 1 > inc_len[i]) begin
                    inc_len[i] = inc_len[j] + 1;
                    pred[i] = j;
                end
        end
        for (int i = set_len - 1; i >= 0; i--) begin
            dec_len[i] = 1;
            succ[i] = i;
            for (int j = set_len - 1; j > i; j--)
                if (set_vals[i] > set_vals[j] && dec_len[j] + 1 > dec_len[i]) begin
                    dec_len[i] = dec_len[j] + 1;
                    succ[i] = j;
                end
        end
        for (int i = 0; i < set_len; i++) begin
            t = inc_len[i] + dec_len[i] - 1;
            if (t > best) begin
                best = t;
                peak = i;
            end
        end
        ninc = inc_len[peak];
        ndec = dec_len[peak];
        idx = peak;
        for (int k = ninc - 1; k >= 0; k--) begin
            chain[k] = idx;
            idx = pred[idx];
        end
        for (int k = 0; k < ninc; k++) begin
            b.elem = set_vals[chain[k]];
            b.part = 1'b0;
            b.total = best[lbs_pkg::TOTAL_W-1:0];
            b.eor = 1'b0;
            subseq_q = {subseq_q, b};
        end
        idx = peak;
        for (int k = 0; k < ndec; k++) begin
            b.elem = set_vals[idx];
            b.part = 1'b1;
            b.total = best[lbs_pkg::TOTAL_W-1:0];
            b.eor = (k == ndec - 1);
            subseq_q = {subseq_q, b};
            idx = succ[idx];
        end
    endtask

    always @(posedge aclk) begin
        chain_beat_t e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            set_len = 0;
            subseq_q.delete();
            pending = 0;
            fail_count <= 0;
            run_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                // Beats past the store depth are dropped, but tlast still closes the set.
                if (set_len < lbs_pkg::MAX_ITEMS) begin
                    set_vals[set_len] = s_tdata;
                    set_len = set_len + 1;
                end
                if (s_tlast) begin
                    predict_subseq();
                    set_len = 0;
                    run_count <= run_count + 1;
                end
            end
            if (m_tvalid && m_tready) begin
                if (subseq_q.size() == 0) begin
                    $error("unexpected result beat %h", m_tdata);
                    errs++;
                end else begin
                    e = subseq_q.pop_front();
                    if (m_tdata[15:0] !== e.elem) begin
                        $error("elem: expected %0d, got %0d", e.elem, $signed(m_tdata[15:0]));
                        errs++;
                    end
                    if (m_tuser !== e.part) begin
                        $error("part: expected %0d, got %0d", e.part, m_tuser);
                        errs++;
                    end
                    if (m_tdata[21:16] !== e.total) begin
                        $error("total_length: expected %0d, got %0d", e.total,
                               m_tdata[21:16]);
                        errs++;
                    end
                    if (m_tlast !== e.eor) begin
                        $error("end_of_run: expected %0d, got %0d", e.eor, m_tlast);
                        errs++;
                    end
                end
            end
            pending = subseq_q.size();
            fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== tb/longest_bitonic_subsequence_test.sv =====
// Stimulus and verdict for the longest bitonic subsequence block.
// Depends on lbs_pkg, longest_bitonic_subsequence and lbs_checker.
`timescale 1ns / 1ps
module longest_bitonic_subsequence_test;

    localparam int IDLE_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tlast = 1'b0, m_tready = 1'b0;
    logic [15:0] s_tdata = '0;
    logic s_tready, m_tvalid, m_tuser, m_tlast;
    logic [lbs_pkg::DATA_W-1:0] m_tdata;
    int fail_count, pending, run_count;
    int beats_sent = 0;
    int idle_cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    longest_bitonic_subsequence DUT (.*);

    lbs_checker checker_i (.*);

    // Receiver may hold tready low before each beat; some beats get no stall at all.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Watchdog on cycles with no accepted beat on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Leaves tvalid high after the beat so that a following beat can go back to back.
    task automatic send_beat(input logic [15:0] v, input logic last, input bit bursty);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= v;
        s_tlast <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        beats_sent++;
    endtask

    task automatic send_set(input logic [15:0] vals[$]);
        bit bursty;
        bursty = ($urandom_range(0, 3) == 0);
        foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1, bursty);
    endtask

    function automatic logic [15:0] pick_value(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 7) - 4);
            1: return 16'($urandom());
            default: return ($urandom_range(0, 1)) ? 16'(16'h7FFF - $urandom_range(0, 2))
                                                     : 16'(16'h8000 + $urandom_range(0, 2));
        endcase
    endfunction

    initial begin
        logic [15:0] vals[$];
        int n, mode;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed sets: single element, extremes, flat, mixed rise and fall, rising, overflow.
        vals = '{16'h8000};                   send_set(vals);
        vals = '{16'h7FFF};                   send_set(vals);
        vals = '{16'h8000, 16'h7FFF, 16'h8000}; send_set(vals);
        vals = '{16'h0005, 16'h0005, 16'h0005}; send_set(vals);
        vals = '{16'h0001, 16'h0002, 16'hFFFF, 16'h0003, 16'h0000}; send_set(vals);
        vals = '{16'hAAAA, 16'h5555};         send_set(vals);
        // Too many beats in one set: the excess are dropped but tlast still closes it.
        vals = {};
        for (int i = 0; i < lbs_pkg::MAX_ITEMS + 3; i++) vals = {vals, 16'(i * 37 - 500)};
        send_set(vals);

        // Pause until the block has answered everything queued so far.
        s_tvalid <= 1'b0;
        wait (pending == 0);

        while (beats_sent < 320) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, lbs_pkg::MAX_ITEMS + 2)
                                            : $urandom_range(1, 10);
            mode = $urandom_range(0, 2);
            vals = {};
            for (int i = 0; i < n; i++) vals = {vals, pick_value(mode)};
            send_set(vals);
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (3000) @(posedge aclk);
        $display("Sent %0d value beats in %0d sets, including oversize and extreme sets.",
                 beats_sent, run_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/lbs_pkg.sv
src/lbs_cell.sv
src/longest_bitonic_subsequence.sv
tb/lbs_checker.sv
tb/longest_bitonic_subsequence_test.sv
